// File: hdl/glos_pkg.sv
// Shared types, constants and helpers of the grid line-of-sight checker.
// No dependencies.
`default_nettype none
package glos_pkg;

  localparam int MAP_CELLS_DEF = 65536;
  localparam int MAX_SIDE      = 256;
  localparam int FRAC_BITS     = 8;
  localparam int SLOPE_FRAC    = 16;
  localparam int SLOPE_ONE     = 1 << SLOPE_FRAC;

  localparam int WIDTH_W = 9;
  localparam int COORD_W = 16;
  localparam int PIX_W   = 19;
  localparam int CELL_W  = 12;
  localparam int STEP_W  = PIX_W - FRAC_BITS;
  localparam int SLOPE_W = 18;
  localparam int ACC_W   = 28;
  localparam int PROD_W  = 28;
  localparam int DVD_W   = 37;
  localparam int DVS_W   = 20;
  localparam int PADDR_W = 3;

  localparam int WORLD_OFS = 100 << FRAC_BITS;
  localparam int PIX_DEN   = 200;

  localparam logic [WIDTH_W-1:0] WIDTH_RST = WIDTH_W'(256);
  localparam logic [0:0] REG_MAP_WIDTH = 1'b0;

  typedef struct packed {
    logic                      mode;
    logic [15:0]               cell_index;
    logic                      cell_blocked;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_z;
  } cmd_t;

  typedef struct packed {
    logic path_clear;
    logic is_query_result;
  } res_t;

  // integer cell of a pixel coordinate, truncated toward zero
  function automatic logic signed [CELL_W-1:0] cell_of(input logic signed [PIX_W-1:0] pix);
    logic signed [PIX_W-1:0] adj;
    adj = pix[PIX_W-1] ? pix + PIX_W'((1 << FRAC_BITS) - 1) : pix;
    return CELL_W'(adj >>> FRAC_BITS);
  endfunction

  // whole cells of a slope product, truncated toward zero
  function automatic logic signed [CELL_W-1:0] acc_cells(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] adj;
    adj = acc[ACC_W-1] ? acc + ACC_W'(SLOPE_ONE - 1) : acc;
    return CELL_W'(adj >>> SLOPE_FRAC);
  endfunction

endpackage
`default_nettype wire

// File: hdl/glos_div.sv
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on glos_pkg.
`default_nettype none
module glos_div #(
  parameter int DVD_W = glos_pkg::DVD_W,
  parameter int DVS_W = glos_pkg::DVS_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [DVS_W-1:0] divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] r;
  logic [DVS_W-1:0] dm;
  logic             neg;
  logic [DVS_W:0]   rs;

  assign rs = {r, q[DVD_W-1]};
  assign quotient = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CNT_W'(DVD_W);
        q   <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        r   <= '0;
        dm  <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
        neg <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
      end else if (run) begin
        if (rs >= {1'b0, dm}) begin
          r <= DVS_W'(rs - {1'b0, dm});
          q <= {q[DVD_W-2:0], 1'b1};
        end else begin
          r <= rs[DVS_W-1:0];
          q <= {q[DVD_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/glos_map.sv
// One-bit obstacle map memory with a clearing pass after reset.
// Depends on glos_pkg for its default size.
`default_nettype none
module glos_map #(
  parameter int MAP_CELLS = glos_pkg::MAP_CELLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [$clog2(MAP_CELLS)-1:0] wr_addr,
  input  logic                         wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(MAP_CELLS)-1:0] rd_addr,
  output logic                         rd_data,
  output logic                         ready
);
  localparam int AW = $clog2(MAP_CELLS);

  logic          mem [MAP_CELLS];
  logic          clearing;
  logic [AW-1:0] clr_addr;

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAP_CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// File: hdl/grid_line_of_sight_check.sv
// Top level of the grid line-of-sight checker: sequencer, map and divider.
// Depends on glos_pkg, glos_div, glos_map.
//
// Usage: a command beat is taken when start is high and busy is low. Mode 0
// writes one cell of the obstacle map; its acknowledge appears on the next
// cycle and busy stays low, so writes go one per cycle. Mode 1 is a query: the
// four end point coordinates are scaled to pixels by a multiply and a
// reciprocal multiply, then the shared divider forms the slope (two divisions
// for steep lines), then the walk visits each cell in turn through cell
// select, bounds and index, map read and test. A query is shortest for a
// vertical segment of no length and longest for a steep line across a
// 256-cell map; its length is set by the one bit per cycle divider and the
// single map read port.
// The result beat is shown on result for one cycle with done high; the
// receiver cannot stall it. Reset starts a clearing pass that writes every
// map cell free, one per cycle; busy is high meanwhile. The user must write
// map_width over the APB port only while idle; the block does not enforce it.
`default_nettype none
module grid_line_of_sight_check #(
  parameter int MAP_CELLS = glos_pkg::MAP_CELLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  glos_pkg::cmd_t               cmd,
  output logic                         busy,
  output logic                         done,
  output glos_pkg::res_t               result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [glos_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import glos_pkg::*;

  localparam int AW = $clog2(MAP_CELLS);
  localparam int IW = (AW > 17) ? AW : 17;

  // x / 200 = ((x >> 3) * ceil(2^26 / 25)) >> 26, exact for |x| < 2^24
  localparam int MAG_W   = 21;
  localparam int RCP_W   = 22;
  localparam int SCL_W   = MAG_W + RCP_W;
  localparam int PIX_SHR = 3;
  localparam int RCP_SHR = 26;
  localparam logic [RCP_W-1:0] RCP_25 = RCP_W'(2684355);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PMUL  = 14'b00000000000010,
    S_PSCL  = 14'b00000000000100,
    S_PSTO  = 14'b00000000001000,
    S_ORDER = 14'b00000000010000,
    S_SPLIT = 14'b00000000100000,
    S_SLOPE = 14'b00000001000000,
    S_SWAPZ = 14'b00000010000000,
    S_STEEP = 14'b00000100000000,
    S_INV   = 14'b00001000000000,
    S_CELL  = 14'b00010000000000,
    S_ADDR  = 14'b00100000000000,
    S_RD    = 14'b01000000000000,
    S_TEST  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [WIDTH_W-1:0] map_width;
  logic [WIDTH_W-1:0] w_eff;
  logic               cfg_wr;

  logic signed [COORD_W-1:0] wi [4];
  logic signed [PIX_W-1:0]   pts [4];
  logic [1:0]                pi;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  wsum;
  logic [PROD_W-1:0]         pmag;
  logic [SCL_W-1:0]          scl;
  logic                      pneg;

  logic                      div_go;
  logic                      div_done;
  logic signed [DVD_W-1:0]   div_dvd;
  logic signed [DVS_W-1:0]   div_dvs;
  logic signed [DVD_W-1:0]   quo;

  logic signed [PIX_W-1:0]   dx;
  logic signed [PIX_W-1:0]   dz;
  logic signed [CELL_W-1:0]  cax;
  logic signed [CELL_W-1:0]  caz;
  logic signed [CELL_W-1:0]  cbz;

  logic                      vert;
  logic                      steep;
  logic signed [SLOPE_W-1:0] slope;
  logic signed [CELL_W-1:0]  c0;
  logic signed [CELL_W-1:0]  r0;
  logic signed [CELL_W-1:0]  rv;
  logic signed [CELL_W-1:0]  lim;
  logic [STEP_W-1:0]         k;
  logic signed [ACC_W-1:0]   acc;
  logic [PIX_W-1:0]          span;
  logic signed [CELL_W-1:0]  tr;
  logic signed [CELL_W-1:0]  col;
  logic signed [CELL_W-1:0]  row;
  logic signed [CELL_W-1:0]  wlim;
  logic [IW-1:0]             idx;
  logic                      fin;

  logic                      accept;
  logic                      map_ready;
  logic                      wr_en;
  logic                      rd_en;
  logic                      rd_data;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_MAP_WIDTH);
  assign prdata = (paddr[PADDR_W-1:2] == REG_MAP_WIDTH) ? 32'(map_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width <= WIDTH_RST;
    end else if (cfg_wr) begin
      map_width <= pwdata[WIDTH_W-1:0];
    end
  end

  assign w_eff = (map_width == '0) ? WIDTH_W'(1) :
                 (map_width > WIDTH_W'(MAX_SIDE)) ? WIDTH_W'(MAX_SIDE) : map_width;
  assign wlim  = CELL_W'(w_eff) - CELL_W'(1);

  assign busy   = (state != S_IDLE) || !map_ready;
  assign accept = start && !busy;
  assign wr_en  = accept && !cmd.mode && (33'(cmd.cell_index) < 33'(MAP_CELLS));
  assign rd_en  = (state == S_RD) && (33'(idx) < 33'(MAP_CELLS));

  assign wsum = PROD_W'(wi[pi]) + PROD_W'(WORLD_OFS);
  assign pmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign dx   = pts[2] - pts[0];
  assign dz   = pts[3] - pts[1];
  assign cax  = cell_of(pts[0]);
  assign caz  = cell_of(pts[1]);
  assign cbz  = cell_of(pts[3]);
  assign tr   = acc_cells(acc);
  assign fin  = vert ? (rv >= lim) : (PIX_W'({k, FRAC_BITS'(0)}) >= span);

  always_comb begin
    case (state)
      S_SLOPE: begin
        div_dvd = DVD_W'(dz) <<< SLOPE_FRAC;
        div_dvs = DVS_W'(dx);
      end
      S_INV: begin
        div_dvd = DVD_W'(dx) <<< SLOPE_FRAC;
        div_dvs = DVS_W'(dz);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!cmd.mode) begin
              done   <= 1'b1;
              result <= '0;
            end else begin
              wi[0] <= cmd.start_x;
              wi[1] <= cmd.start_z;
              wi[2] <= cmd.end_x;
              wi[3] <= cmd.end_z;
              pi    <= '0;
              state <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          prod  <= wsum * PROD_W'(w_eff);
          state <= S_PSCL;
        end
        S_PSCL: begin
          scl   <= SCL_W'(MAG_W'(pmag >> PIX_SHR)) * SCL_W'(RCP_25);
          pneg  <= prod[PROD_W-1];
          state <= S_PSTO;
        end
        S_PSTO: begin
          pts[pi] <= pneg ? -PIX_W'(scl >> RCP_SHR) : PIX_W'(scl >> RCP_SHR);
          pi      <= pi + 2'd1;
          state   <= (pi == 2'd3) ? S_ORDER : S_PMUL;
        end
        S_ORDER: begin
          if (pts[2] < pts[0]) begin
            pts[0] <= pts[2];
            pts[2] <= pts[0];
            pts[1] <= pts[3];
            pts[3] <= pts[1];
          end
          state <= S_SPLIT;
        end
        S_SPLIT: begin
          if (dx == '0) begin
            vert  <= 1'b1;
            steep <= 1'b0;
            c0    <= cax;
            rv    <= (cbz < caz) ? cbz : caz;
            lim   <= (cbz < caz) ? caz : cbz;
            state <= S_CELL;
          end else begin
            div_go <= 1'b1;
            state  <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          if (div_done) begin
            if (quo < DVD_W'(SLOPE_ONE) && quo >= -DVD_W'(SLOPE_ONE)) begin
              slope <= quo[SLOPE_W-1:0];
              vert  <= 1'b0;
              steep <= 1'b0;
              c0    <= cax;
              r0    <= caz;
              k     <= '0;
              acc   <= '0;
              span  <= dx;
              state <= S_CELL;
            end else begin
              state <= S_SWAPZ;
            end
          end
        end
        S_SWAPZ: begin
          if (pts[3] < pts[1]) begin
            pts[0] <= pts[2];
            pts[2] <= pts[0];
            pts[1] <= pts[3];
            pts[3] <= pts[1];
          end
          state <= S_STEEP;
        end
        S_STEEP: begin
          if (dz == '0) begin
            done   <= 1'b1;
            result <= '{path_clear: 1'b1, is_query_result: 1'b1};
            state  <= S_IDLE;
          end else begin
            div_go <= 1'b1;
            state  <= S_INV;
          end
        end
        S_INV: begin
          if (div_done) begin
            slope <= quo[SLOPE_W-1:0];
            vert  <= 1'b0;
            steep <= 1'b1;
            c0    <= cax;
            r0    <= caz;
            k     <= '0;
            acc   <= '0;
            span  <= dz;
            state <= S_CELL;
          end
        end
        S_CELL: begin
          if (fin) begin
            done   <= 1'b1;
            result <= '{path_clear: 1'b1, is_query_result: 1'b1};
            state  <= S_IDLE;
          end else begin
            col   <= vert ? c0 : (steep ? c0 + tr : c0 + CELL_W'(k));
            row   <= vert ? rv : (steep ? r0 + CELL_W'(k) : r0 + tr);
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (col < 0 || row < 0 || col > wlim || row > wlim) begin
            done   <= 1'b1;
            result <= '{path_clear: 1'b0, is_query_result: 1'b1};
            state  <= S_IDLE;
          end else begin
            idx   <= IW'(row) * IW'(w_eff) + IW'(col);
            state <= S_RD;
          end
        end
        S_RD: begin
          if (!rd_en) begin
            done   <= 1'b1;
            result <= '{path_clear: 1'b0, is_query_result: 1'b1};
            state  <= S_IDLE;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (rd_data) begin
            done   <= 1'b1;
            result <= '{path_clear: 1'b0, is_query_result: 1'b1};
            state  <= S_IDLE;
          end else begin
            k     <= k + STEP_W'(1);
            acc   <= acc + ACC_W'(slope);
            rv    <= rv + CELL_W'(1);
            state <= S_CELL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  glos_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(quo)
  );

  glos_map #(
    .MAP_CELLS(MAP_CELLS)
  ) u_map (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (wr_en),
    .wr_addr(AW'(cmd.cell_index)),
    .wr_data(cmd.cell_blocked),
    .rd_en  (rd_en),
    .rd_addr(AW'(idx)),
    .rd_data(rd_data),
    .ready  (map_ready)
  );
endmodule
`default_nettype wire

// File: hdl/glos_chk.sv
// Port-level checker for the grid line-of-sight checker, bound to the top.
// Depends on glos_pkg and grid_line_of_sight_check.
`default_nettype none
module glos_chk (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input glos_pkg::cmd_t cmd,
  input logic           busy,
  input logic           done,
  input glos_pkg::res_t result,
  input logic           psel,
  input logic           penable,
  input logic           pready
);
  // clearing pass holds off commands right after reset
  a_clear_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // a write beat is acknowledged on the next cycle
  a_write_ack: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !cmd.mode |=> done && !result.is_query_result && !result.path_clear)
    else $error("write beat not acknowledged");

  // a query beat starts work: busy is high and done low once it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.mode |=> busy && !done)
    else $error("query beat did not start work");

  // a result beat never coincides with ongoing work
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("pready low in access cycle");
endmodule

bind grid_line_of_sight_check glos_chk u_chk (.*);
`default_nettype wire
